// ===== design/bpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and constants of the block pool with queues: request and
// response layouts, operation and status codes, decoded operation record.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int NUM_QUEUES = 4;
  localparam int NUM_LIMITS = 4;
  localparam int FIFO_DEPTH = 2;

  localparam int BLK_W     = 7;
  localparam int BLK_AW    = $clog2(NUM_BLOCKS);
  localparam int QID_W     = 2;
  localparam int QSEL_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int LIMIT_W   = 7;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W  = 3;

  localparam logic [BLK_W-1:0]   BLK_NONE    = BLK_W'(NUM_BLOCKS);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_PUT   = 2'd2,
    FUNC_GET   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_EXHAUSTED = 3'd1,
    STATUS_NULL      = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [BLK_W-1:0]   block_index;
    logic [QID_W-1:0]   queue_id;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [BLK_W-1:0]   result_block;
    logic [CNT_W-1:0]   queue_length;
  } rsp_t;

  // request after classification in the front end
  typedef struct packed {
    func_t              func;
    logic               blk_ok;
    logic [BLK_AW-1:0]  blk_addr;
    logic [QSEL_W-1:0]  queue;
  } op_t;

  // next link of an entry that has not been written since reset
  function automatic logic [BLK_W-1:0] next_reset_val(input logic [BLK_AW-1:0] addr);
    logic [BLK_W-1:0] val;
    if (addr == BLK_AW'(NUM_BLOCKS - 1)) begin
      val = BLK_NONE;
    end else begin
      val = BLK_W'(addr) + BLK_W'(1);
    end
    return val;
  endfunction

endpackage

// ===== design/block_pool_with_fifo_queues.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_pool_with_fifo_queues
// Fixed-block pool allocator with a LIFO free list and bounded FIFO queues.
// ----------------------------------------------------------------------------
// Each request (allocate, free, put, get) returns exactly one response in
// request order. The back end takes one request at a time: a fetch state
// reads the next-link and prev-link memories, then an execute state updates
// links and pointers and loads the response register, waiting while a held
// response is stalled. A two-entry request queue in front keeps accepting
// while the back end works or the response waits. Link memories need no
// clearing pass after reset; queue limits can be written at any idle time.
module block_pool_with_fifo_queues (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  bpq_pkg::req_t                 req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output bpq_pkg::rsp_t                 rsp_data,
  input  logic                          cfg_we,
  input  logic [bpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpq_pkg::LIMIT_W-1:0]   cfg_data
);
  import bpq_pkg::*;

  logic op_valid;
  op_t  op;
  logic op_pop;

  bpq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .op_valid  (op_valid),
    .op        (op),
    .op_pop    (op_pop)
  );

  bpq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .op_pop    (op_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

// ===== design/bpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bpq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_front
// Request intake: classifies each request (null block, queue select) and
// holds it in a short queue until the back end picks it up.
// ----------------------------------------------------------------------------
module bpq_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bpq_pkg::req_t  req_data,
  output logic           op_valid,
  output bpq_pkg::op_t   op,
  input  logic           op_pop
);
  import bpq_pkg::*;

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  op_t               fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FCNT_W-1:0] count;
  op_t               op_in;
  logic              push;

  always_comb begin
    op_in.func     = req_data.func;
    op_in.blk_ok   = req_data.block_index < BLK_W'(NUM_BLOCKS);
    op_in.blk_addr = req_data.block_index[BLK_AW-1:0];
    // queue count is a power of two, so the id wraps by truncation
    op_in.queue    = req_data.queue_id[QSEL_W-1:0];
  end

  assign req_stall = (count == FCNT_W'(FIFO_DEPTH));
  assign push      = req_valid && !req_stall;
  assign op_valid  = (count != '0);
  assign op        = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (op_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + FCNT_W'(push) - FCNT_W'(op_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= op_in;
    end
  end

endmodule

// ===== design/bpq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_back
// Operation engine: reads the link memories in a fetch cycle, then updates
// free list, queue pointers and links and writes the response register.
// ----------------------------------------------------------------------------
module bpq_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              op_valid,
  input  bpq_pkg::op_t                      op,
  output logic                              op_pop,
  input  logic                              cfg_we,
  input  logic [bpq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpq_pkg::LIMIT_W-1:0]       cfg_data,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output bpq_pkg::rsp_t                     rsp_data
);
  import bpq_pkg::*;

  typedef enum logic [1:0] {
    S_FETCH = 2'b01,
    S_EXEC  = 2'b10
  } state_t;

  state_t              state;
  op_t                 op_r;
  logic [BLK_W-1:0]    free_head;
  logic [BLK_W-1:0]    queue_head  [NUM_QUEUES];
  logic [BLK_W-1:0]    queue_tail  [NUM_QUEUES];
  logic [CNT_W-1:0]    queue_count [NUM_QUEUES];
  logic [LIMIT_W-1:0]  queue_limit [NUM_LIMITS];
  logic [NUM_BLOCKS-1:0] next_written;
  logic [NUM_BLOCKS-1:0] prev_written;

  logic                next_we;
  logic [BLK_AW-1:0]   next_waddr;
  logic [BLK_W-1:0]    next_wdata;
  logic [BLK_W-1:0]    next_q;
  logic                prev_we;
  logic [BLK_AW-1:0]   prev_waddr;
  logic [BLK_W-1:0]    prev_wdata;
  logic [BLK_W-1:0]    prev_q;

  logic                commit;
  logic [BLK_W-1:0]    free_head_next;
  logic [BLK_W-1:0]    head_next;
  logic [BLK_W-1:0]    tail_next;
  logic [CNT_W-1:0]    count_next;
  rsp_t                rsp_next;

  assign op_pop = (state == S_FETCH) && op_valid;
  assign commit = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  bpq_ram #(
    .WIDTH (BLK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (op_pop),
    .raddr (free_head[BLK_AW-1:0]),
    .rdata (next_q)
  );

  bpq_ram #(
    .WIDTH (BLK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (op_pop),
    .raddr (queue_tail[op.queue][BLK_AW-1:0]),
    .rdata (prev_q)
  );

  always_comb begin
    logic [BLK_W-1:0]   fh;
    logic               fh_ok;
    logic [BLK_W-1:0]   next_rd;
    logic [BLK_W-1:0]   tail;
    logic               tail_ok;
    logic [BLK_W-1:0]   prev_rd;
    logic [BLK_W-1:0]   head;
    logic               head_ok;
    logic [CNT_W-1:0]   cnt;
    logic [LIMIT_W-1:0] lim;
    logic [BLK_W-1:0]   blk;

    fh      = free_head;
    fh_ok   = fh < BLK_W'(NUM_BLOCKS);
    // entries never written since reset read as their reset links
    next_rd = next_written[fh[BLK_AW-1:0]] ? next_q : next_reset_val(fh[BLK_AW-1:0]);
    tail    = queue_tail[op_r.queue];
    tail_ok = tail < BLK_W'(NUM_BLOCKS);
    prev_rd = prev_written[tail[BLK_AW-1:0]] ? prev_q : BLK_NONE;
    head    = queue_head[op_r.queue];
    head_ok = head < BLK_W'(NUM_BLOCKS);
    cnt     = queue_count[op_r.queue];
    lim     = queue_limit[op_r.queue];
    blk     = BLK_W'(op_r.blk_addr);

    next_we        = 1'b0;
    next_waddr     = op_r.blk_addr;
    next_wdata     = BLK_NONE;
    prev_we        = 1'b0;
    prev_waddr     = op_r.blk_addr;
    prev_wdata     = BLK_NONE;
    free_head_next = fh;
    head_next      = head;
    tail_next      = tail;
    count_next     = cnt;
    rsp_next.status       = STATUS_OK;
    rsp_next.result_block = BLK_NONE;
    rsp_next.queue_length = '0;

    unique case (op_r.func)
      FUNC_ALLOC: begin
        if (!fh_ok) begin
          rsp_next.status = STATUS_EXHAUSTED;
        end else begin
          free_head_next        = next_rd;
          next_we               = 1'b1;
          next_waddr            = fh[BLK_AW-1:0];
          prev_we               = 1'b1;
          prev_waddr            = fh[BLK_AW-1:0];
          rsp_next.result_block = fh;
        end
      end
      FUNC_FREE: begin
        if (!op_r.blk_ok) begin
          rsp_next.status = STATUS_NULL;
        end else begin
          next_we        = 1'b1;
          next_wdata     = fh;
          prev_we        = 1'b1;
          free_head_next = blk;
        end
      end
      FUNC_PUT: begin
        if (!op_r.blk_ok) begin
          rsp_next.status = STATUS_NULL;
        end else if (CNT_W'(cnt) >= CNT_W'(lim)) begin
          rsp_next.status = STATUS_FULL;
        end else begin
          next_we    = 1'b1;
          next_wdata = head;
          prev_we    = head_ok;
          prev_waddr = head[BLK_AW-1:0];
          prev_wdata = blk;
          head_next  = blk;
          count_next = cnt + CNT_W'(1);
          if (cnt == '0) begin
            tail_next = blk;
          end
        end
        rsp_next.queue_length = count_next;
      end
      FUNC_GET: begin
        if (cnt == '0) begin
          rsp_next.status = STATUS_EMPTY;
        end else if (!tail_ok) begin
          // count says nonempty but the tail is lost: drop the queue
          rsp_next.status = STATUS_EMPTY;
          count_next      = '0;
          head_next       = BLK_NONE;
        end else begin
          count_next = cnt - CNT_W'(1);
          tail_next  = prev_rd;
          if (cnt == CNT_W'(1)) begin
            head_next = BLK_NONE;
          end
          next_we               = 1'b1;
          next_waddr            = tail[BLK_AW-1:0];
          prev_we               = 1'b1;
          prev_waddr            = tail[BLK_AW-1:0];
          rsp_next.result_block = tail;
        end
        rsp_next.queue_length = count_next;
      end
      default: begin
        rsp_next.status = STATUS_OK;
      end
    endcase

    next_we = next_we && commit;
    prev_we = prev_we && commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FETCH;
      free_head    <= '0;
      next_written <= '0;
      prev_written <= '0;
      rsp_valid    <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        queue_head[i]  <= BLK_NONE;
        queue_tail[i]  <= BLK_NONE;
        queue_count[i] <= '0;
      end
      for (int i = 0; i < NUM_LIMITS; i++) begin
        queue_limit[i] <= LIMIT_RESET;
      end
    end else begin
      if (cfg_we) begin
        queue_limit[cfg_index] <= cfg_data;
      end
      unique case (state)
        S_FETCH: begin
          if (op_pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_FETCH;
          end
        end
        default: begin
          state <= S_FETCH;
        end
      endcase
      if (commit) begin
        free_head               <= free_head_next;
        queue_head[op_r.queue]  <= head_next;
        queue_tail[op_r.queue]  <= tail_next;
        queue_count[op_r.queue] <= count_next;
        rsp_valid               <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (next_we) begin
        next_written[next_waddr] <= 1'b1;
      end
      if (prev_we) begin
        prev_written[prev_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      op_r <= op;
    end
    if (commit) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

// ===== design/bpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks of the block pool: response count against requests,
// response field consistency and response hold under stall.
// ----------------------------------------------------------------------------
module bpq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_stall,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input bpq_pkg::rsp_t                 rsp_data
);
  import bpq_pkg::*;

  logic       req_acc;
  logic       rsp_acc;
  logic [2:0] outstanding;

  assign req_acc = req_valid && !req_stall;
  assign rsp_acc = rsp_valid && !rsp_stall;

  // requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(req_acc) - 3'(rsp_acc);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  a_err_no_block: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != STATUS_OK) |-> rsp_data.result_block == BLK_NONE)
    else $error("error response carries a block");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> outstanding != 3'd0)
    else $error("response without a pending request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'd4)
    else $error("more requests in flight than the pipeline holds");

endmodule

bind block_pool_with_fifo_queues bpq_checker u_bpq_checker (.*);

// ===== dv/block_pool_with_fifo_queues_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_pool_with_fifo_queues_tb
// Self-checking bench for the block pool. A directed table covers the
// allocate, free, put and get corner cases: null blocks, full and empty
// queues, a broken tail and pool exhaustion. Random phases follow, each under
// its own set of queue limits. An in-bench pool predictor computes each expected
// response not fixed by the table; the bench throttles both handshakes at random.
// ----------------------------------------------------------------------------
module block_pool_with_fifo_queues_tb;
  import bpq_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_IDLE     = 12;
  localparam int LONG_HOLD    = 90;
  localparam int SETTLE       = 8;
  localparam int NONE_IDX     = NUM_BLOCKS;
  localparam int N_DIR        = 23;
  localparam int PHASE_ITEMS  = 130;

  typedef struct {
    func_t   op;
    int      blk;
    int      qid;
    bit      fixed;
    status_t st;
    int      res;
    int      len;
  } dir_row_t;

  // rows with fixed set carry their response; the rest go through the predictor
  dir_row_t dir_rows [N_DIR] = '{
    '{FUNC_ALLOC, 0,        0, 1, STATUS_OK,        0,        0},
    '{FUNC_ALLOC, 0,        0, 1, STATUS_OK,        1,        0},
    '{FUNC_FREE,  NONE_IDX, 0, 1, STATUS_NULL,      NONE_IDX, 0},
    '{FUNC_FREE,  127,      3, 1, STATUS_NULL,      NONE_IDX, 0},
    '{FUNC_PUT,   NONE_IDX, 0, 1, STATUS_NULL,      NONE_IDX, 0},
    '{FUNC_GET,   0,        1, 1, STATUS_EMPTY,     NONE_IDX, 0},
    '{FUNC_PUT,   0,        0, 1, STATUS_OK,        NONE_IDX, 1},
    '{FUNC_PUT,   1,        0, 1, STATUS_FULL,      NONE_IDX, 1},
    '{FUNC_PUT,   127,      0, 1, STATUS_NULL,      NONE_IDX, 1},
    '{FUNC_GET,   0,        0, 1, STATUS_OK,        0,        0},
    '{FUNC_FREE,  0,        0, 1, STATUS_OK,        NONE_IDX, 0},
    '{FUNC_ALLOC, 0,        0, 0, STATUS_OK,        0,        0},
    // free a block still on queue 1: its prev link goes to none
    '{FUNC_PUT,   0,        1, 0, STATUS_OK,        0,        0},
    '{FUNC_PUT,   1,        1, 0, STATUS_OK,        0,        0},
    '{FUNC_FREE,  0,        1, 0, STATUS_OK,        0,        0},
    '{FUNC_GET,   0,        1, 0, STATUS_OK,        0,        0},
    // count still one but tail lost
    '{FUNC_GET,   0,        1, 1, STATUS_EMPTY,     NONE_IDX, 0},
    '{FUNC_ALLOC, 0,        0, 0, STATUS_OK,        0,        0},
    '{FUNC_ALLOC, 0,        0, 1, STATUS_EXHAUSTED, NONE_IDX, 0},
    '{FUNC_PUT,   63,       3, 0, STATUS_OK,        0,        0},
    '{FUNC_GET,   0,        3, 0, STATUS_OK,        0,        0},
    '{FUNC_GET,   0,        2, 1, STATUS_EMPTY,     NONE_IDX, 0},
    '{FUNC_PUT,   NONE_IDX, 2, 1, STATUS_NULL,      NONE_IDX, 0}
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req_data  = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data  = '0;

  // predictor state
  logic [BLK_W-1:0]   link_next [NUM_BLOCKS];
  logic [BLK_W-1:0]   link_prev [NUM_BLOCKS];
  logic [BLK_W-1:0]   free_top;
  logic [BLK_W-1:0]   q_head    [NUM_QUEUES];
  logic [BLK_W-1:0]   q_tail    [NUM_QUEUES];
  logic [CNT_W-1:0]   q_count   [NUM_QUEUES];
  logic [LIMIT_W-1:0] q_limit   [NUM_LIMITS];

  rsp_t             pending_rsp [$];
  logic [BLK_W-1:0] owned_blks  [$];   // allocated and on no queue
  int               mismatches    = 0;
  int               req_idle_max  = MAX_IDLE;
  int               rsp_idle_max  = MAX_IDLE;
  bit               hold_rsp_long = 1'b0;

  block_pool_with_fifo_queues i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic rsp_t pool_step(input req_t r);
    rsp_t             o;
    logic [BLK_W-1:0] b;
    logic [BLK_W-1:0] h;
    logic [BLK_W-1:0] t;
    logic [LIMIT_W-1:0] lim;
    int               q;
    o.status       = STATUS_OK;
    o.result_block = BLK_NONE;
    o.queue_length = '0;
    b   = r.block_index;
    q   = int'(r.queue_id) % NUM_QUEUES;
    lim = (q < NUM_LIMITS) ? q_limit[q] : LIMIT_RESET;
    case (r.func)
      FUNC_ALLOC: begin
        if (free_top >= NUM_BLOCKS) begin
          o.status = STATUS_EXHAUSTED;
        end else begin
          h = free_top;
          free_top = link_next[h];
          link_next[h] = BLK_NONE;
          link_prev[h] = BLK_NONE;
          o.result_block = h;
        end
      end
      FUNC_FREE: begin
        if (b >= NUM_BLOCKS) begin
          o.status = STATUS_NULL;
        end else begin
          link_next[b] = free_top;
          free_top = b;
          link_prev[b] = BLK_NONE;
        end
      end
      FUNC_PUT: begin
        if (b >= NUM_BLOCKS) begin
          o.status = STATUS_NULL;
        end else if (q_count[q] >= lim) begin
          o.status = STATUS_FULL;
        end else begin
          h = q_head[q];
          link_next[b] = h;
          if (h < NUM_BLOCKS) link_prev[h] = b;
          q_head[q] = b;
          q_count[q] = q_count[q] + 1'b1;
          if (q_count[q] == 1) q_tail[q] = b;
        end
        o.queue_length = q_count[q];
      end
      default: begin
        t = q_tail[q];
        if (q_count[q] == 0) begin
          o.status = STATUS_EMPTY;
        end else if (t >= NUM_BLOCKS) begin
          o.status = STATUS_EMPTY;
          q_count[q] = '0;
          q_head[q] = BLK_NONE;
        end else begin
          q_count[q] = q_count[q] - 1'b1;
          q_tail[q] = link_prev[t];
          if (q_count[q] == 0) q_head[q] = BLK_NONE;
          link_prev[t] = BLK_NONE;
          link_next[t] = BLK_NONE;
          o.result_block = t;
        end
        o.queue_length = q_count[q];
      end
    endcase
    return o;
  endfunction

  // offer one request, wait for it to be taken, then record what it should return
  task automatic issue(input req_t r, input bit fixed, input rsp_t fixed_rsp,
                       output rsp_t pred);
    int gap;
    gap = (req_idle_max > 0) ? $urandom_range(0, req_idle_max) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = pool_step(r);
    pending_rsp.push_back(fixed ? fixed_rsp : pred);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] l0, input logic [LIMIT_W-1:0] l1,
                            input logic [LIMIT_W-1:0] l2, input logic [LIMIT_W-1:0] l3);
    logic [LIMIT_W-1:0] vals [NUM_LIMITS];
    vals[0] = l0;
    vals[1] = l1;
    vals[2] = l2;
    vals[3] = l3;
    for (int i = 0; i < NUM_LIMITS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      q_limit[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic next_setting(input logic [LIMIT_W-1:0] l0, input logic [LIMIT_W-1:0] l1,
                              input logic [LIMIT_W-1:0] l2, input logic [LIMIT_W-1:0] l3);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    set_limits(l0, l1, l2, l3);
  endtask

  // mostly well-formed traffic on owned blocks, a little null and misuse noise
  task automatic run_phase(input int n_items, input int w_alloc, input int w_free,
                           input int w_put, input bit pause_mid);
    req_t r;
    rsp_t pred;
    int   sel;
    int   slot;
    for (int n = 0; n < n_items; n++) begin
      if (pause_mid && n == n_items / 2) wait_idle();
      sel  = $urandom_range(0, 99);
      slot = -1;
      r.queue_id    = QID_W'($urandom_range(0, 3));
      r.block_index = BLK_W'($urandom_range(0, 127));
      if (sel >= 94) begin
        r.func = func_t'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 7) r.block_index = BLK_W'($urandom_range(NONE_IDX, 127));
        else r.block_index = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
      end else if (sel < w_alloc ||
                   (owned_blks.size() == 0 && sel < w_alloc + w_free + w_put)) begin
        r.func = FUNC_ALLOC;
      end else if (sel < w_alloc + w_free + w_put) begin
        r.func = (sel < w_alloc + w_free) ? FUNC_FREE : FUNC_PUT;
        slot = $urandom_range(0, owned_blks.size() - 1);
        r.block_index = owned_blks[slot];
      end else begin
        r.func = FUNC_GET;
      end
      if (slot < 0 && (r.func == FUNC_FREE || r.func == FUNC_PUT)) begin
        foreach (owned_blks[k]) if (owned_blks[k] == r.block_index) slot = k;
      end
      issue(r, 1'b0, pred, pred);
      if (pred.status == STATUS_OK) begin
        if (r.func == FUNC_ALLOC || r.func == FUNC_GET) owned_blks.push_back(pred.result_block);
        else if (slot >= 0) owned_blks.delete(slot);
      end
    end
  endtask

  initial begin : rsp_sink
    int   w;
    rsp_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = (rsp_idle_max > 0) ? $urandom_range(0, rsp_idle_max) : 0;
      if (hold_rsp_long) begin
        w = LONG_HOLD;
        hold_rsp_long = 1'b0;
      end
      if (w > 0) begin
        rsp_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with no request outstanding: status %0d block %0d length %0d",
                 $time, rsp_data.status, rsp_data.result_block, rsp_data.queue_length);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_data.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, rsp_data.status);
          mismatches++;
        end
        if (rsp_data.result_block !== want.result_block) begin
          $display("%0t: result_block expected %0d, actual %0d",
                   $time, want.result_block, rsp_data.result_block);
          mismatches++;
        end
        if (rsp_data.queue_length !== want.queue_length) begin
          $display("%0t: queue_length expected %0d, actual %0d",
                   $time, want.queue_length, rsp_data.queue_length);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("block_pool_with_fifo_queues regression: fail");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    rsp_t pred;
    rsp_t fixed_rsp;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      link_next[i] = (i == NUM_BLOCKS - 1) ? BLK_NONE : BLK_W'(i + 1);
      link_prev[i] = BLK_NONE;
    end
    free_top = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      q_head[i]  = BLK_NONE;
      q_tail[i]  = BLK_NONE;
      q_count[i] = '0;
    end
    for (int i = 0; i < NUM_LIMITS; i++) q_limit[i] = LIMIT_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_limits(7'd1, 7'd64, 7'd2, 7'd64);

    for (int i = 0; i < N_DIR; i++) begin
      r.func                 = dir_rows[i].op;
      r.block_index          = BLK_W'(dir_rows[i].blk);
      r.queue_id             = QID_W'(dir_rows[i].qid);
      fixed_rsp.status       = dir_rows[i].st;
      fixed_rsp.result_block = BLK_W'(dir_rows[i].res);
      fixed_rsp.queue_length = CNT_W'(dir_rows[i].len);
      issue(r, dir_rows[i].fixed, fixed_rsp, pred);
    end

    // the table leaves the free list broken; rebuild it as 0, 1, ... 63
    for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
      r.func        = FUNC_FREE;
      r.block_index = BLK_W'(b);
      r.queue_id    = QID_W'($urandom_range(0, 3));
      issue(r, 1'b0, fixed_rsp, pred);
    end

    next_setting(7'd4, 7'd1, 7'd64, 7'd2);
    run_phase(PHASE_ITEMS, 30, 15, 30, 1'b0);

    // back-to-back traffic into a long response hold, pool runs dry
    next_setting(7'd64, 7'd64, 7'd64, 7'd64);
    req_idle_max  = 0;
    rsp_idle_max  = 0;
    hold_rsp_long = 1'b1;
    run_phase(PHASE_ITEMS, 45, 5, 35, 1'b0);

    next_setting(LIMIT_W'($urandom_range(1, 64)), LIMIT_W'($urandom_range(1, 64)),
                 LIMIT_W'($urandom_range(1, 64)), LIMIT_W'($urandom_range(1, 64)));
    req_idle_max = MAX_IDLE;
    rsp_idle_max = MAX_IDLE;
    run_phase(PHASE_ITEMS, 15, 20, 25, 1'b1);

    next_setting(7'd1, 7'd64, 7'd1, 7'd64);
    rsp_idle_max = 0;
    run_phase(PHASE_ITEMS, 30, 15, 30, 1'b0);

    next_setting(LIMIT_W'($urandom_range(1, 64)), LIMIT_W'($urandom_range(1, 64)),
                 LIMIT_W'($urandom_range(1, 64)), LIMIT_W'($urandom_range(1, 64)));
    rsp_idle_max = MAX_IDLE;
    run_phase(PHASE_ITEMS, 28, 17, 30, 1'b0);

    wait_idle();
    repeat (2 * SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("block_pool_with_fifo_queues regression: pass");
    end else begin
      $display("block_pool_with_fifo_queues regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bpq_pkg.sv
design/bpq_ram.sv
design/bpq_front.sv
design/bpq_back.sv
design/block_pool_with_fifo_queues.sv
design/bpq_checker.sv
dv/block_pool_with_fifo_queues_tb.sv
